/* rtl/utfl_pkg.sv */
// Package for the unwind table frame lookup block.
// Store geometry, entry layouts, status and function codes. No dependencies.
package utfl_pkg;
  localparam int SEGMENTS   = 64;
  localparam int ENTRIES    = 1024;
  localparam int RA_ENTRIES = 64;
  localparam int SEG_AW = $clog2(SEGMENTS);
  localparam int ENT_AW = $clog2(ENTRIES);
  localparam int RA_AW  = $clog2(RA_ENTRIES);

  localparam logic [1:0] FUNC_SEG    = 2'd0;
  localparam logic [1:0] FUNC_ENT    = 2'd1;
  localparam logic [1:0] FUNC_RA     = 2'd2;
  localparam logic [1:0] FUNC_LOOKUP = 2'd3;

  localparam logic [1:0] ST_FRAMED  = 2'd0;
  localparam logic [1:0] ST_LEAF    = 2'd1;
  localparam logic [1:0] ST_NOKEY   = 2'd2;
  localparam logic [1:0] ST_BAD_RA  = 2'd3;

  localparam logic CFG_SEG_COUNT = 1'b0;
  localparam logic CFG_RA_COUNT  = 1'b1;

  typedef struct packed {
    logic [15:0] tag;
    logic [9:0]  first;
    logic [9:0]  last;
  } seg_t;

  typedef struct packed {
    logic [15:0] saf;
    logic [15:0] words;
    logic [15:0] bytes;
  } ent_t;

  typedef struct packed {
    logic [9:0]  key;
    logic [15:0] value;
  } ra_t;
endpackage

/* rtl/utfl_ram.sv */
// Generic single-port synchronous RAM, registered read.
// No dependencies.
module utfl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

/* rtl/unwind_table_frame_lookup.sv */
// Unwind table frame lookup top level: segment scan, two binary searches.
// Depends on utfl_pkg and utfl_ram.
//
// channel | dir | handshake          | payload
// in_     | in  | in_valid/in_ready  | func, slot, load fields, pc, sp
// out_    | out | out_valid/out_ready| status, addresses, matched entry fields
// cfg_    | in  | cfg_we             | cfg_index, cfg_wdata
//
// Load transactions write their store when accepted. A lookup has a read
// and a check state per segment scanned, per entry search step (up to 11)
// and per RA search step (up to 7), then best-entry and final states.
// One transaction at a time. Reset clears control state; stores are unset.
// A pending result holds until out_ready; the next transaction waits for it.
module unwind_table_frame_lookup (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              in_func,
  input  logic [9:0]              in_slot,
  input  logic [15:0]             in_segment_tag,
  input  logic [9:0]              in_first_entry,
  input  logic [9:0]              in_last_entry,
  input  logic [15:0]             in_start_and_flag,
  input  logic [15:0]             in_frame_words,
  input  logic [15:0]             in_code_bytes,
  input  logic [9:0]              in_ra_key,
  input  logic signed [15:0]      in_ra_value,
  input  logic [31:0]             in_pc,
  input  logic [31:0]             in_sp,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [1:0]              out_status,
  output logic [31:0]             out_ra_address,
  output logic [31:0]             out_next_sp,
  output logic [15:0]             out_func_start,
  output logic [15:0]             out_found_frame_words,
  output logic [15:0]             out_found_code_bytes,
  output logic signed [15:0]      out_ra_word_offset,
  output logic [9:0]              out_matched_entry,
  input  logic                    cfg_we,
  input  logic                    cfg_index,
  input  logic [6:0]              cfg_wdata
);
  import utfl_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SEGRD  = 4'd1;
  localparam logic [3:0] S_SEGCHK = 4'd2;
  localparam logic [3:0] S_ENTRD  = 4'd3;
  localparam logic [3:0] S_ENTCHK = 4'd4;
  localparam logic [3:0] S_BESTRD = 4'd5;
  localparam logic [3:0] S_BESTCK = 4'd6;
  localparam logic [3:0] S_RARD   = 4'd7;
  localparam logic [3:0] S_RACHK  = 4'd8;
  localparam logic [3:0] S_FINAL  = 4'd9;
  localparam logic [3:0] S_OUT    = 4'd10;

  logic [3:0] state_r;
  logic [6:0] seg_cnt_r, ra_cnt_r;
  logic [31:0] pc_r, sp_r;
  logic [6:0] seg_i_r;
  logic signed [11:0] lo_r, hi_r;
  logic [9:0] best_r;
  logic found_r;
  logic [15:0] saf_r, words_r, bytes_r, off_r;

  logic [SEG_AW-1:0] seg_addr;
  logic [ENT_AW-1:0] ent_addr;
  logic [RA_AW-1:0]  ra_addr;
  logic seg_we, ent_we, ra_we;
  seg_t seg_q;
  ent_t ent_q;
  ra_t  ra_q;

  logic [6:0] nseg, nra;
  logic signed [11:0] mid;
  logic [15:0] s_cl;
  logic [31:0] raddr, nsp;

  assign nseg = (seg_cnt_r > 7'(SEGMENTS)) ? 7'(SEGMENTS) : seg_cnt_r;
  assign nra  = (ra_cnt_r > 7'(RA_ENTRIES)) ? 7'(RA_ENTRIES) : ra_cnt_r;
  assign mid  = (lo_r + hi_r) >>> 1;
  assign s_cl = ent_q.saf & 16'hFFFE;

  assign in_ready = (state_r == S_IDLE);
  wire acc = in_valid && in_ready;

  assign seg_we = acc && in_func == FUNC_SEG && in_slot < 10'(SEGMENTS);
  assign ent_we = acc && in_func == FUNC_ENT && 11'(in_slot) < 11'(ENTRIES);
  assign ra_we  = acc && in_func == FUNC_RA && in_slot < 10'(RA_ENTRIES);

  always_comb begin
    seg_addr = seg_i_r[SEG_AW-1:0];
    ent_addr = mid[ENT_AW-1:0];
    ra_addr  = mid[RA_AW-1:0];
    if (state_r == S_IDLE) begin
      seg_addr = in_slot[SEG_AW-1:0];
      ent_addr = in_slot[ENT_AW-1:0];
      ra_addr  = in_slot[RA_AW-1:0];
    end else if (state_r == S_BESTRD || state_r == S_BESTCK) begin
      ent_addr = best_r[ENT_AW-1:0];
    end
  end

  utfl_ram #(.WIDTH($bits(seg_t)), .DEPTH(SEGMENTS)) u_seg (
    .clk(clk), .we(seg_we), .addr(seg_addr),
    .wdata({in_segment_tag, in_first_entry, in_last_entry}), .rdata(seg_q));
  utfl_ram #(.WIDTH($bits(ent_t)), .DEPTH(ENTRIES)) u_ent (
    .clk(clk), .we(ent_we), .addr(ent_addr),
    .wdata({in_start_and_flag, in_frame_words, in_code_bytes}), .rdata(ent_q));
  utfl_ram #(.WIDTH($bits(ra_t)), .DEPTH(RA_ENTRIES)) u_ra (
    .clk(clk), .we(ra_we), .addr(ra_addr),
    .wdata({in_ra_key, in_ra_value}), .rdata(ra_q));

  assign raddr = sp_r + {{14{off_r[15]}}, off_r, 2'b00};
  assign nsp   = sp_r + {14'd0, words_r, 2'b00};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      seg_cnt_r <= '0;
      ra_cnt_r  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_SEG_COUNT) seg_cnt_r <= cfg_wdata;
        else ra_cnt_r <= cfg_wdata;
      end
      case (state_r)
        S_IDLE: begin
          if (acc && in_func == FUNC_LOOKUP) begin
            pc_r    <= in_pc;
            sp_r    <= in_sp;
            seg_i_r <= '0;
            state_r <= S_SEGRD;
          end
        end
        S_SEGRD: begin
          if (seg_i_r >= nseg) begin
            found_r <= 1'b0;
            state_r <= S_FINAL;
          end else begin
            state_r <= S_SEGCHK;
          end
        end
        S_SEGCHK: begin
          if (seg_q.tag == pc_r[31:16]) begin
            lo_r    <= 12'(seg_q.first);
            hi_r    <= 12'(seg_q.last);
            found_r <= 1'b0;
            state_r <= S_ENTRD;
          end else begin
            seg_i_r <= seg_i_r + 7'd1;
            state_r <= S_SEGRD;
          end
        end
        S_ENTRD: begin
          if (lo_r > hi_r) state_r <= found_r ? S_BESTRD : S_FINAL;
          else state_r <= S_ENTCHK;
        end
        S_ENTCHK: begin
          if (s_cl == pc_r[15:0]) begin
            best_r <= mid[9:0]; found_r <= 1'b1; state_r <= S_BESTRD;
          end else if (s_cl < pc_r[15:0]) begin
            best_r <= mid[9:0]; found_r <= 1'b1; lo_r <= mid + 12'sd1;
            state_r <= S_ENTRD;
          end else if (mid == 12'sd0) begin
            state_r <= found_r ? S_BESTRD : S_FINAL;
          end else begin
            hi_r <= mid - 12'sd1;
            state_r <= S_ENTRD;
          end
        end
        S_BESTRD: state_r <= S_BESTCK;
        S_BESTCK: begin
          saf_r   <= ent_q.saf;
          words_r <= ent_q.words;
          bytes_r <= ent_q.bytes;
          off_r   <= ent_q.words - 16'd1;
          lo_r    <= '0;
          hi_r    <= 12'(nra) - 12'sd1;
          state_r <= ent_q.saf[0] ? S_RARD : S_FINAL;
        end
        S_RARD: begin
          if (lo_r > hi_r) begin
            off_r   <= 16'hFFFF;
            state_r <= S_FINAL;
          end else begin
            state_r <= S_RACHK;
          end
        end
        S_RACHK: begin
          if (ra_q.key == best_r) begin
            off_r   <= ra_q.value;
            state_r <= S_FINAL;
          end else if (ra_q.key < best_r) begin
            lo_r    <= mid + 12'sd1;
            state_r <= S_RARD;
          end else begin
            hi_r    <= mid - 12'sd1;
            state_r <= S_RARD;
          end
        end
        S_FINAL: begin
          out_valid <= 1'b1;
          state_r   <= S_OUT;
          if (found_r) begin
            out_func_start <= saf_r & 16'hFFFE;
            out_found_frame_words <= words_r;
            out_found_code_bytes  <= bytes_r;
            out_matched_entry     <= best_r;
            out_ra_word_offset    <= off_r;
            if (saf_r[0] && off_r[15]) begin
              out_ra_address <= sp_r;
              out_next_sp    <= sp_r;
              out_status     <= ST_NOKEY;
            end else begin
              out_ra_address <= raddr;
              out_next_sp    <= nsp;
              out_status <= (raddr < sp_r || raddr > nsp) ? ST_BAD_RA : ST_FRAMED;
            end
          end else begin
            out_ra_address <= sp_r;
            out_next_sp    <= sp_r;
            out_func_start <= '0;
            out_found_frame_words <= '0;
            out_found_code_bytes  <= '0;
            out_ra_word_offset    <= '0;
            out_matched_entry     <= '0;
            out_status <= ST_LEAF;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state_r   <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

/* rtl/utfl_checker.sv */
// Port-level checker for unwind_table_frame_lookup, bound to the top level.
// Depends on utfl_pkg.
module utfl_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [31:0] out_ra_address,
  input logic [31:0] out_next_sp,
  input logic [15:0] out_found_frame_words
);
  import utfl_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_ra_address))
    else $error("result dropped while stalled");
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input taken while result pending");
  a_leaf_sp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_LEAF || out_status == ST_NOKEY)
      |-> out_ra_address == out_next_sp)
    else $error("leaf result with differing addresses");
  a_leaf_words: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_LEAF |-> out_found_frame_words == 16'd0)
    else $error("leaf result carries frame size");
endmodule

bind unwind_table_frame_lookup utfl_checker u_utfl_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
  .out_ra_address(out_ra_address), .out_next_sp(out_next_sp),
  .out_found_frame_words(out_found_frame_words));
